@@ rtl/core/ptw_pkg.sv @@
// Shared types, constants and index helpers for the four-level page table walker.
// No dependencies.
`default_nettype none

package ptw_pkg;

  // Table store depth is 2**MemAw words; word index is byte address bits [MemAw+2:3].
  localparam int unsigned MemAw    = 12;
  localparam int unsigned MemWords = 1 << MemAw;

  localparam int unsigned PaW   = 52;
  localparam int unsigned WordW = 64;

  typedef enum logic [1:0] {
    OpStore     = 2'd0,
    OpTranslate = 2'd1,
    OpUnmap     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StsDone  = 2'd0,
    StsFault = 2'd1,
    StsNoMap = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    Lvl4K = 2'd0,
    Lvl2M = 2'd1,
    Lvl1G = 2'd2
  } level_e;

  typedef logic [MemAw-1:0] mem_addr_t;

  // Word slot of entry idx in the table whose frame is given (bits 51:12).
  function automatic mem_addr_t entry_slot(logic [39:0] frame, logic [8:0] idx);
    logic [48:0] word;
    word = {frame, idx};
    return word[MemAw-1:0];
  endfunction

  // Table index of a virtual address at walk level 3..0.
  function automatic logic [8:0] va_index(logic [63:0] va, logic [1:0] lvl);
    logic [8:0] idx;
    case (lvl)
      2'd3:    idx = va[47:39];
      2'd2:    idx = va[38:30];
      2'd1:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ptw_req_if.sv @@
// Request channel of the page table walker: valid/ready plus request payload.
// Depends on ptw_pkg.
`default_nettype none

interface ptw_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [63:0]               address;
  logic [ptw_pkg::WordW-1:0] write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input address, input write_data,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/ptw_rsp_if.sv @@
// Response channel of the page table walker: valid/ready plus result payload.
// Depends on ptw_pkg.
`default_nettype none

interface ptw_rsp_if;
  logic                    valid;
  logic                    ready;
  logic [ptw_pkg::PaW-1:0] physical_address;
  logic [1:0]              status;
  logic [1:0]              page_level;

  modport source (output valid, output physical_address, output status, output page_level,
                  input ready);
  modport sink   (input valid, input physical_address, input status, input page_level,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/four_level_page_table_walker.sv @@
// Four-level page table walker: table store memory, walk sequencer, result register.
// Depends on ptw_pkg, ptw_req_if, ptw_rsp_if.
// Store, fault and unused opcode finish from the start state into the result register;
//   a walk first reads one table entry per level from the store, up to four levels.
// A new request is taken only after the last one has finished into the result register.
// Reset: a clearing pass zeroes all MemWords (4096) store words, with no request taken.
`default_nettype none

module four_level_page_table_walker (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [ptw_pkg::PaW-1:0] cfg_wdata_i,
  ptw_req_if.sink                      req_i,
  ptw_rsp_if.source                    rsp_o
);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StStart,
    StWalk
  } state_e;

  state_e                     state_q, state_d;
  ptw_pkg::mem_addr_t         clr_q, clr_d;
  logic [ptw_pkg::PaW-1:0]    root_q, root_d;
  logic [1:0]                 op_q, op_d;
  logic [63:0]                addr_q, addr_d;
  logic [ptw_pkg::WordW-1:0]  wdata_q, wdata_d;
  logic [1:0]                 lvl_q, lvl_d;
  ptw_pkg::mem_addr_t         slot_q, slot_d;
  logic                       rsp_valid_q, rsp_valid_d;
  logic [ptw_pkg::PaW-1:0]    pa_q, pa_d;
  logic [1:0]                 status_q, status_d;
  logic [1:0]                 level_q, level_d;

  logic [ptw_pkg::WordW-1:0]  mem_q [ptw_pkg::MemWords];
  logic [ptw_pkg::WordW-1:0]  rdata_q;
  logic                       mem_we, mem_re;
  ptw_pkg::mem_addr_t         mem_waddr, mem_raddr;
  logic [ptw_pkg::WordW-1:0]  mem_wdata;

  logic                       out_free, fin, fin_we;
  logic [ptw_pkg::PaW-1:0]    fin_pa;
  logic [1:0]                 fin_status, fin_level;
  logic                       canonical, present, page_sz;

  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign canonical = (addr_q[63:48] == {16{addr_q[47]}});
  assign present   = rdata_q[0];
  assign page_sz   = rdata_q[7];

  assign req_i.ready            = (state_q == StIdle);
  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.physical_address = pa_q;
  assign rsp_o.status           = status_q;
  assign rsp_o.page_level       = level_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    root_d      = cfg_we_i ? cfg_wdata_i : root_q;
    op_d        = op_q;
    addr_d      = addr_q;
    wdata_d     = wdata_q;
    lvl_d       = lvl_q;
    slot_d      = slot_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    pa_d        = pa_q;
    status_d    = status_q;
    level_d     = level_q;

    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = slot_q;

    fin        = 1'b0;
    fin_we     = 1'b0;
    fin_pa     = '0;
    fin_status = ptw_pkg::StsDone;
    fin_level  = ptw_pkg::Lvl4K;

    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (req_i.valid) begin
          op_d    = req_i.operation;
          addr_d  = req_i.address;
          wdata_d = req_i.write_data;
          state_d = StStart;
        end
      end
      StStart: begin
        if (op_q == ptw_pkg::OpStore) begin
          fin       = 1'b1;
          fin_we    = 1'b1;
          mem_waddr = addr_q[ptw_pkg::MemAw+2:3];
          mem_wdata = wdata_q;
        end else if (op_q == ptw_pkg::OpTranslate || op_q == ptw_pkg::OpUnmap) begin
          if (!canonical) begin
            fin        = 1'b1;
            fin_status = ptw_pkg::StsFault;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ptw_pkg::entry_slot(root_q[51:12], ptw_pkg::va_index(addr_q, 2'd3));
            slot_d    = mem_raddr;
            lvl_d     = 2'd3;
            state_d   = StWalk;
          end
        end else begin
          fin = 1'b1;
        end
      end
      StWalk: begin
        if (lvl_q == 2'd0) begin
          fin       = 1'b1;
          fin_level = ptw_pkg::Lvl4K;
          if (op_q == ptw_pkg::OpUnmap) begin
            fin_we     = 1'b1;
            fin_status = present ? ptw_pkg::StsDone : ptw_pkg::StsNoMap;
          end else if (present) begin
            fin_pa = {rdata_q[51:12], addr_q[11:0]};
          end else begin
            fin_status = ptw_pkg::StsNoMap;
          end
        end else if (!present) begin
          fin        = 1'b1;
          fin_status = ptw_pkg::StsNoMap;
        end else if (lvl_q != 2'd3 && page_sz) begin
          fin       = 1'b1;
          fin_level = lvl_q;
          if (op_q == ptw_pkg::OpUnmap) begin
            fin_we = 1'b1;
          end else if (lvl_q == 2'd2) begin
            fin_pa = {rdata_q[51:30], addr_q[29:0]};
          end else begin
            fin_pa = {rdata_q[51:21], addr_q[20:0]};
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptw_pkg::entry_slot(rdata_q[51:12],
                                          ptw_pkg::va_index(addr_q, lvl_q - 2'd1));
          slot_d    = mem_raddr;
          lvl_d     = lvl_q - 2'd1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Finish only when the result register can take the result; the store is held otherwise.
    if (fin && out_free) begin
      mem_we      = fin_we;
      rsp_valid_d = 1'b1;
      pa_d        = fin_pa;
      status_d    = fin_status;
      level_d     = fin_level;
      state_d     = StIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      root_q      <= '0;
      op_q        <= '0;
      addr_q      <= '0;
      wdata_q     <= '0;
      lvl_q       <= '0;
      slot_q      <= '0;
      rsp_valid_q <= 1'b0;
      pa_q        <= '0;
      status_q    <= '0;
      level_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      root_q      <= root_d;
      op_q        <= op_d;
      addr_q      <= addr_d;
      wdata_q     <= wdata_d;
      lvl_q       <= lvl_d;
      slot_q      <= slot_d;
      rsp_valid_q <= rsp_valid_d;
      pa_q        <= pa_d;
      status_q    <= status_d;
      level_q     <= level_d;
    end
  end

  // Table store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/ptw_walk_checker.sv @@
// Checker for the four-level page table walker: watches config, request and response ports,
// predicts every walk from its own copy of the table store and compares results in order.
// Depends on ptw_pkg.
`timescale 1ns / 100ps

module ptw_walk_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ptw_pkg::PaW-1:0]     cfg_wdata_i,
  input  wire logic                        req_valid_i,
  input  wire logic                        req_ready_i,
  input  wire logic [1:0]                  req_operation_i,
  input  wire logic [63:0]                 req_address_i,
  input  wire logic [ptw_pkg::WordW-1:0]   req_write_data_i,
  input  wire logic                        rsp_valid_i,
  input  wire logic                        rsp_ready_i,
  input  wire logic [ptw_pkg::PaW-1:0]     rsp_physical_address_i,
  input  wire logic [1:0]                  rsp_status_i,
  input  wire logic [1:0]                  rsp_page_level_i,
  output int unsigned                      errors_o,
  output int unsigned                      pending_o,
  output int unsigned                      checked_o
);
  import ptw_pkg::*;

  typedef struct packed {
    logic [PaW-1:0] pa;
    status_e        sts;
    level_e         lvl;
  } walk_res_t;

  logic [WordW-1:0] shadow_mem [MemWords];
  logic [PaW-1:0]   root_base;
  walk_res_t        pending_walks [$];
  int unsigned      fails;
  int unsigned      checked;

  // Word slot of entry idx in the table at byte address tbl (frame bits only).
  function automatic logic [MemAw-1:0] entry_word(logic [63:0] tbl, logic [8:0] idx);
    logic [63:0] byte_a;
    byte_a = {12'd0, tbl[51:12], 12'd0} + {52'd0, idx, 3'd0};
    return byte_a[MemAw+2:3];
  endfunction

  // Applies one transaction to the shadow store and returns the result it must produce.
  function automatic walk_res_t walk_tables(logic [1:0] op, logic [63:0] va,
                                            logic [63:0] wd);
    walk_res_t        res;
    logic [63:0]      tbl;
    logic [63:0]      ent;
    logic [MemAw-1:0] slot;
    bit               stop;
    res.pa  = '0;
    res.sts = StsDone;
    res.lvl = Lvl4K;
    stop    = 1'b0;
    tbl     = {12'd0, root_base};
    if (op == OpStore) begin
      shadow_mem[va[MemAw+2:3]] = wd;
    end else if (op == OpTranslate || op == OpUnmap) begin
      if (va[63:48] != {16{va[47]}}) begin
        res.sts = StsFault;
      end else begin
        for (int l = 3; l >= 0; l--) begin
          if (!stop) begin
            slot = entry_word(tbl, va[12 + 9 * l +: 9]);
            ent  = shadow_mem[slot];
            if (l == 0) begin
              stop = 1'b1;
              if (op == OpUnmap) begin
                shadow_mem[slot] = '0;
                res.sts = ent[0] ? StsDone : StsNoMap;
              end else if (ent[0]) begin
                res.pa = {ent[51:12], va[11:0]};
              end else begin
                res.sts = StsNoMap;
              end
            end else if (!ent[0]) begin
              stop    = 1'b1;
              res.sts = StsNoMap;
            end else if (l < 3 && ent[7]) begin
              stop    = 1'b1;
              res.lvl = (l == 2) ? Lvl1G : Lvl2M;
              if (op == OpUnmap) begin
                shadow_mem[slot] = '0;
              end else if (l == 2) begin
                res.pa = {ent[51:30], va[29:0]};
              end else begin
                res.pa = {ent[51:21], va[20:0]};
              end
            end else begin
              tbl = ent;
            end
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    walk_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MemWords; i++) shadow_mem[i] = '0;
      root_base = '0;
      pending_walks.delete();
      fails     = 0;
      checked   = 0;
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        root_base = cfg_wdata_i;
      end
      if (rsp_valid_i && rsp_ready_i) begin
        checked++;
        if (pending_walks.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected result: pa=%h status=%0d level=%0d",
                     rsp_physical_address_i, rsp_status_i, rsp_page_level_i);
          end
          fails++;
        end else begin
          want = pending_walks.pop_front();
          if (rsp_physical_address_i !== want.pa || rsp_status_i !== want.sts ||
              rsp_page_level_i !== want.lvl) begin
            if (fails < 10) begin
              $display("mismatch: expected pa=%h status=%0d level=%0d", want.pa,
                       want.sts, want.lvl);
              $display("          actual   pa=%h status=%0d level=%0d",
                       rsp_physical_address_i, rsp_status_i, rsp_page_level_i);
            end
            fails++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        pending_walks.push_back(walk_tables(req_operation_i, req_address_i,
                                            req_write_data_i));
      end
      errors_o  <= fails;
      pending_o <= pending_walks.size();
      checked_o <= checked;
    end
  end

endmodule

@@ tb/sv/tb_four_level_page_table_walker.sv @@
// Top of the page table walker testbench: clock, reset, request and response pacing,
// directed and random table-building walks; verdict from ptw_walk_checker.
// Depends on ptw_pkg, ptw_req_if, ptw_rsp_if, ptw_walk_checker and the walker itself.
`timescale 1ns / 100ps

module tb_four_level_page_table_walker;
  import ptw_pkg::*;

  localparam logic [1:0]  OpUnused   = 2'd3;
  localparam int unsigned PhaseItems = 180;
  localparam int unsigned Phases     = 5;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 500000;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [PaW-1:0] cfg_wdata_i;
  logic [PaW-1:0] root_now;
  int unsigned    sent_cnt;
  int unsigned    burst_left;
  int unsigned    hold_reqs;
  int unsigned    roots_set;
  int unsigned    cycles;
  int unsigned    op_count [4];
  int unsigned    chk_errors;
  int unsigned    chk_pending;
  int unsigned    chk_checked;

  ptw_req_if req_if ();
  ptw_rsp_if rsp_if ();

  four_level_page_table_walker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  ptw_walk_checker u_checker (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .req_valid_i            (req_if.valid),
    .req_ready_i            (req_if.ready),
    .req_operation_i        (req_if.operation),
    .req_address_i          (req_if.address),
    .req_write_data_i       (req_if.write_data),
    .rsp_valid_i            (rsp_if.valid),
    .rsp_ready_i            (rsp_if.ready),
    .rsp_physical_address_i (rsp_if.physical_address),
    .rsp_status_i           (rsp_if.status),
    .rsp_page_level_i       (rsp_if.page_level),
    .errors_o               (chk_errors),
    .pending_o              (chk_pending),
    .checked_o              (chk_checked)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, chk_pending);
      $display("tb_four_level_page_table_walker: errors");
      $finish;
    end
  end

  // Response side: random stall pattern, sometimes all ready, plus a long hold on request.
  initial begin : rsp_pacing
    int unsigned hold_left;
    int unsigned hold_seen;
    int unsigned tick;
    logic [7:0]  pat;
    hold_left = 0;
    hold_seen = 0;
    tick      = 0;
    pat       = 8'hFF;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (tick % 48 == 0) begin
        pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
      end
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= pat[tick % 8];
      end
    end
  end

  // One request transaction, then the burst/gap pacing of the sender.
  task automatic send_req(input logic [1:0] op, input logic [63:0] addr,
                          input logic [63:0] wd);
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.address    <= addr;
    req_if.write_data <= wd;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    op_count[op]++;
    sent_cnt++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 32);
      req_if.valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4))
        @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
  endtask

  task automatic write_root(input logic [PaW-1:0] base);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= base;
    root_now = base;
    roots_set++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic store_slot(input logic [MemAw-1:0] slot, input logic [63:0] ent);
    logic [63:0] addr;
    addr = {$urandom, $urandom};
    addr[MemAw+2:3] = slot;
    send_req(OpStore, addr, ent);
  endtask

  function automatic logic [63:0] rand_canon();
    logic [63:0] va;
    va = {$urandom, $urandom};
    va[63:48] = {16{va[47]}};
    return va;
  endfunction

  function automatic logic [63:0] make_entry(logic [2:0] page, logic present, logic ps);
    logic [63:0] ent;
    ent = {$urandom, $urandom};
    ent[14:12] = page;
    ent[7]     = ps;
    ent[0]     = present;
    return ent;
  endfunction

  // Builds a path for one address (sometimes with a missing level), then walks it.
  task automatic walk_scenario();
    logic [63:0] va;
    logic [63:0] vb;
    logic [2:0]  pg2;
    logic [2:0]  pg1;
    logic [2:0]  pg0;
    level_e      leaf;
    int unsigned hole;
    va   = rand_canon();
    pg2  = 3'($urandom_range(0, 7));
    pg1  = 3'($urandom_range(0, 7));
    pg0  = 3'($urandom_range(0, 7));
    leaf = level_e'($urandom_range(0, 2));
    hole = $urandom_range(0, 15);
    store_slot({root_now[14:12], va[47:39]},
               make_entry(pg2, hole != 3, 1'($urandom_range(0, 1))));
    store_slot({pg2, va[38:30]}, make_entry(pg1, hole != 2, leaf == Lvl1G));
    if (leaf != Lvl1G) begin
      store_slot({pg1, va[29:21]}, make_entry(pg0, hole != 1, leaf == Lvl2M));
    end
    if (leaf == Lvl4K) begin
      store_slot({pg0, va[20:12]}, make_entry(3'($urandom_range(0, 7)), hole != 0,
                                              1'($urandom_range(0, 1))));
    end
    repeat ($urandom_range(1, 4)) begin
      vb = va;
      case (leaf)
        Lvl4K:   vb[11:0] = 12'($urandom);
        Lvl2M:   vb[20:0] = 21'($urandom);
        default: vb[29:0] = 30'($urandom);
      endcase
      send_req(($urandom_range(0, 4) == 0) ? OpUnmap : OpTranslate, vb,
               {$urandom, $urandom});
    end
  endtask

  task automatic noise_burst();
    logic [63:0] addr;
    logic [1:0]  op;
    repeat ($urandom_range(1, 5)) begin
      op   = 2'($urandom_range(0, 3));
      addr = {$urandom, $urandom};
      if (op != OpStore && $urandom_range(0, 1) == 1) addr[63:48] = {16{addr[47]}};
      send_req(op, addr, {$urandom, $urandom});
    end
  endtask

  initial begin : stimulus
    logic [PaW-1:0] root_val;
    int unsigned    phase_end;
    req_if.valid      <= 1'b0;
    req_if.operation  <= OpStore;
    req_if.address    <= '0;
    req_if.write_data <= '0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    rst_ni            <= 1'b0;
    burst_left = 8;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // low 12 bits of the root are don't-care
    write_root(52'h0_0000_0000_0ABC);

    // empty tables, non-canonical faults, unused opcode
    send_req(OpTranslate, 64'h0000_0000_0000_0000, '0);
    send_req(OpUnmap,     64'h0000_0000_3FFF_FFFF, '0);
    send_req(OpTranslate, 64'h0000_8000_0000_0000, '0);
    send_req(OpUnmap,     64'hFFFF_7FFF_FFFF_FFFF, '0);
    send_req(OpUnused,    '1, '1);
    // 4 KiB path for the top address; top entry has PS set and high bits set
    send_req(OpStore, 64'h0000_0000_0000_0FF8, 64'hFFFF_FFFF_FFFF_9081);
    send_req(OpStore, 64'h0000_0000_0000_1FF8, 64'h0000_0000_0000_2003);
    send_req(OpStore, 64'h0000_0000_0000_2FF8, 64'h0000_0000_0000_3001);
    send_req(OpStore, 64'h0000_0000_0000_3FFF, 64'h800F_FFFF_FFFF_F0E3);
    send_req(OpTranslate, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_req(OpTranslate, 64'hFFFF_FFFF_FFFF_F000, '0);
    send_req(OpUnmap,     64'hFFFF_FFFF_FFFF_F123, '0);
    send_req(OpTranslate, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_req(OpUnmap,     64'hFFFF_FFFF_FFFF_FFFF, '0);
    // 2 MiB and 1 GiB leaves
    send_req(OpStore, 64'h0000_0000_0000_2FF8, 64'h000A_BCDE_F1E0_0081);
    send_req(OpTranslate, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_req(OpStore, 64'h0000_0000_0000_1FF8, 64'h0001_2345_C000_0081);
    send_req(OpTranslate, 64'hFFFF_FFFF_C123_4567, '0);
    send_req(OpUnmap,     64'hFFFF_FFFF_C123_4567, '0);
    send_req(OpTranslate, 64'hFFFF_FFFF_C123_4567, '0);
    // store addresses that wrap around the table store
    send_req(OpStore, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_4001);
    send_req(OpStore, 64'hFFFF_FFFF_FFFF_C000, 64'h0000_0000_4000_0081);
    send_req(OpTranslate, 64'h0000_0000_3FFF_FFFF, '0);
    send_req(OpStore, 64'hFFFF_FFFF_FFFF_FFFF, '1);

    for (int ph = 0; ph < Phases; ph++) begin
      wait_drained();
      case (ph)
        0:       root_val = '1;
        2:       root_val = '0;
        default: root_val = {20'($urandom), $urandom};
      endcase
      write_root(root_val);
      if (ph == 1) hold_reqs <= hold_reqs + 1;
      for (int half = 0; half < 2; half++) begin
        phase_end = sent_cnt + PhaseItems / 2;
        while (sent_cnt < phase_end) begin
          if ($urandom_range(0, 9) < 8) walk_scenario();
          else noise_burst();
        end
        if (ph == 3 && half == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("covered %0d requests (%0d store, %0d translate, %0d unmap, %0d unused op)",
             sent_cnt, op_count[OpStore], op_count[OpTranslate], op_count[OpUnmap],
             op_count[OpUnused]);
    $display("%0d root table bases, %0d results compared, %0d failures",
             roots_set, chk_checked, chk_errors);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("tb_four_level_page_table_walker: clean");
    end else begin
      $display("tb_four_level_page_table_walker: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ptw_pkg.sv
rtl/core/ptw_req_if.sv
rtl/core/ptw_rsp_if.sv
rtl/core/four_level_page_table_walker.sv
tb/sv/ptw_walk_checker.sv
tb/sv/tb_four_level_page_table_walker.sv
